// ----- hw/rtl/awbq_pkg.sv -----
// ----------------------------------------------------------------------------
// awbq_pkg: shared types and constants
// Sizes, operation codes and word layouts for the bucketed queue.
// ----------------------------------------------------------------------------
package awbq_pkg;

  localparam int NUM_CATEGORIES = 32;
  localparam int CATEGORY_DEPTH = 16;

  localparam int CAT_W   = $clog2(NUM_CATEGORIES);
  localparam int SLOT_W  = $clog2(CATEGORY_DEPTH);
  localparam int FILL_W  = $clog2(CATEGORY_DEPTH + 1);
  localparam int ADDR_W  = CAT_W + SLOT_W;
  localparam int RAM_DEPTH = NUM_CATEGORIES << SLOT_W;

  localparam int MODE_W    = 3;
  localparam int CLAUSE_W  = 32;
  localparam int PAYLOAD_W = 32;
  localparam int CATF_W    = 5;
  localparam int RATIO_W   = 8;
  localparam int ENTRY_W   = CLAUSE_W + PAYLOAD_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  typedef enum logic [MODE_W-1:0] {
    OP_INSERT = 3'd0,
    OP_SELECT = 3'd1,
    OP_POP    = 3'd2,
    OP_CANCEL = 3'd3,
    OP_PEEK   = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATIO = 1'b0,
    REG_PRIO  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN_RD,
    B_SCAN_CMP,
    B_READ,
    B_RESP
  } back_state_t;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [CLAUSE_W-1:0]  clause_number;
    logic [CAT_W-1:0]     category;
    logic [PAYLOAD_W-1:0] payload;
  } cmd_t;

  typedef struct packed {
    logic                 ok;
    logic [CLAUSE_W-1:0]  out_clause_number;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [CATF_W-1:0]    out_category;
    logic                 by_weight;
  } rsp_t;

endpackage

// ----- hw/rtl/awbq_if.sv -----
// ----------------------------------------------------------------------------
// awbq_if: request and response channels
// Valid/ready channels carrying the request and result words.
// ----------------------------------------------------------------------------
interface awbq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] clause_number;
  logic [4:0]  weight_category;
  logic [31:0] payload;
  modport source(output valid, mode, clause_number, weight_category, payload, input ready);
  modport sink(input valid, mode, clause_number, weight_category, payload, output ready);
endinterface

interface awbq_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] out_clause_number;
  logic [31:0] out_payload;
  logic [4:0]  out_category;
  logic        by_weight;
  modport source(output valid, ok, out_clause_number, out_payload, out_category, by_weight,
                 input ready);
  modport sink(input valid, ok, out_clause_number, out_payload, out_category, by_weight,
               output ready);
endinterface

// ----- hw/rtl/awbq_ram.sv -----
// ----------------------------------------------------------------------------
// awbq_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module awbq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- hw/rtl/awbq_front.sv -----
// ----------------------------------------------------------------------------
// awbq_front: request intake
// Accepts request words, maps the insert category, queues up to two commands.
// ----------------------------------------------------------------------------
module awbq_front (
  input  logic                   clk,
  input  logic                   rst,
  awbq_req_if.sink               req,
  input  logic [awbq_pkg::RATIO_W-1:0] ratio,
  input  logic                   prio_mode,
  output logic                   cmd_valid,
  output awbq_pkg::cmd_t         cmd,
  input  logic                   cmd_pop
);
  import awbq_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;
  logic [CAT_W-1:0] cat_map;

  // category zero when forced or ratio off; saturate past the last one
  always_comb begin
    if (prio_mode || ratio == '0) begin
      cat_map = '0;
    end else if (32'(req.weight_category) >= NUM_CATEGORIES) begin
      cat_map = CAT_W'(NUM_CATEGORIES - 1);
    end else begin
      cat_map = CAT_W'(req.weight_category);
    end
  end

  always_comb begin
    cmd_in.mode          = req.mode;
    cmd_in.clause_number = req.clause_number;
    cmd_in.category      = cat_map;
    cmd_in.payload       = req.payload;
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end
endmodule

// ----- hw/rtl/awbq_back.sv -----
// ----------------------------------------------------------------------------
// awbq_back: queue engine
// Holds the category rings and executes one command at a time.
// ----------------------------------------------------------------------------
module awbq_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [awbq_pkg::RATIO_W-1:0] ratio,
  input  logic                   cmd_valid,
  input  awbq_pkg::cmd_t         cmd,
  output logic                   cmd_pop,
  awbq_rsp_if.source             rsp
);
  import awbq_pkg::*;

  back_state_t state, state_next;

  logic [SLOT_W-1:0] head [NUM_CATEGORIES];
  logic [SLOT_W-1:0] tail [NUM_CATEGORIES];
  logic [FILL_W-1:0] fill [NUM_CATEGORIES];
  logic [RATIO_W-1:0] owed;
  logic [CAT_W-1:0]   sel_cat;
  logic               last_bw;

  logic [NUM_CATEGORIES-1:0] nonempty;
  logic [CAT_W-1:0] low_cat, high_cat;
  logic             all_empty;

  logic [CAT_W-1:0]    scan_i;
  logic                best_valid;
  logic [CLAUSE_W-1:0] best_clause;
  logic [PAYLOAD_W-1:0] best_payload;
  logic [CAT_W-1:0]    best_cat;
  logic                take;

  rsp_t res;
  rsp_t res_idle;
  rsp_t o_res;
  logic o_valid;
  logic o_load;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_q;

  logic [CAT_W-1:0]  c_ins;
  logic [SLOT_W-1:0] tail_prev;
  logic [CAT_W-1:0]  sel_first;
  logic              sel_first_bw;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(CATEGORY_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(CATEGORY_DEPTH - 1) : s - 1'b1;
  endfunction

  // occupancy summary
  always_comb begin
    for (int i = 0; i < NUM_CATEGORIES; i++) begin
      nonempty[i] = (fill[i] != '0);
    end
    all_empty = (nonempty == '0);
    low_cat   = '0;
    high_cat  = '0;
    for (int i = NUM_CATEGORIES - 1; i >= 0; i--) begin
      if (nonempty[i]) low_cat = CAT_W'(i);
    end
    for (int i = 0; i < NUM_CATEGORIES; i++) begin
      if (nonempty[i]) high_cat = CAT_W'(i);
    end
  end

  assign c_ins        = cmd.category;
  assign tail_prev    = slot_dec(tail[high_cat]);
  assign sel_first    = nonempty[0] ? '0 : low_cat;
  assign sel_first_bw = !nonempty[0] && (owed != '0);
  assign take = nonempty[scan_i] &&
                (!best_valid || ram_q[ENTRY_W-1:PAYLOAD_W] < best_clause);
  assign o_load = !o_valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.mode)
            OP_INSERT: state_next = B_RESP;
            OP_SELECT: begin
              if (all_empty) state_next = B_RESP;
              else if (nonempty[0] || owed != '0) state_next = B_READ;
              else state_next = B_SCAN_RD;
            end
            OP_POP:    state_next = (fill[sel_cat] == '0) ? B_RESP : B_READ;
            OP_CANCEL, OP_PEEK: state_next = all_empty ? B_RESP : B_READ;
            default:   state_next = B_RESP;
          endcase
        end
      end
      B_SCAN_RD:  state_next = B_SCAN_CMP;
      B_SCAN_CMP: state_next = (scan_i == high_cat) ? B_RESP : B_SCAN_RD;
      B_READ:     state_next = B_RESP;
      B_RESP:     state_next = o_load ? B_IDLE : B_RESP;
      default:    state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop   = (state == B_IDLE) && cmd_valid;
    ram_we    = 1'b0;
    ram_addr  = {sel_cat, head[sel_cat]};
    ram_wdata = {cmd.clause_number, cmd.payload};
    case (state)
      B_IDLE: begin
        case (cmd.mode)
          OP_INSERT: begin
            ram_addr = {c_ins, tail[c_ins]};
            ram_we   = cmd_valid && (32'(fill[c_ins]) < CATEGORY_DEPTH);
          end
          OP_SELECT: ram_addr = {sel_first, head[sel_first]};
          OP_CANCEL, OP_PEEK: ram_addr = {high_cat, tail_prev};
          default: ram_addr = {sel_cat, head[sel_cat]};
        endcase
      end
      B_SCAN_RD: ram_addr = {scan_i, head[scan_i]};
      default:   ram_addr = {sel_cat, head[sel_cat]};
    endcase
  end

  // result fields known when the command is taken; data fields follow the read
  always_comb begin
    res_idle = '0;
    if (cmd_valid) begin
      case (cmd.mode)
        OP_INSERT: begin
          if (ram_we) begin
            res_idle.ok                = 1'b1;
            res_idle.out_clause_number = cmd.clause_number;
            res_idle.out_payload       = cmd.payload;
            res_idle.out_category      = CATF_W'(c_ins);
          end
        end
        OP_SELECT: begin
          res_idle.ok           = !all_empty;
          res_idle.out_category = all_empty ? '0 : CATF_W'(sel_first);
          res_idle.by_weight    = !all_empty && sel_first_bw;
        end
        OP_POP: begin
          res_idle.ok           = (fill[sel_cat] != '0);
          res_idle.out_category = (fill[sel_cat] != '0) ? CATF_W'(sel_cat) : '0;
          res_idle.by_weight    = (fill[sel_cat] != '0) && last_bw;
        end
        OP_CANCEL, OP_PEEK: begin
          res_idle.ok           = !all_empty;
          res_idle.out_category = all_empty ? '0 : CATF_W'(high_cat);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      owed    <= '0;
      sel_cat <= '0;
      last_bw <= 1'b0;
      o_valid <= 1'b0;
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == B_RESP && o_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      if (state == B_IDLE && cmd_valid) begin
        case (cmd.mode)
          OP_INSERT: begin
            if (ram_we) begin
              tail[c_ins] <= slot_inc(tail[c_ins]);
              fill[c_ins] <= fill[c_ins] + 1'b1;
            end
          end
          OP_SELECT: begin
            if (!all_empty && (nonempty[0] || owed != '0)) begin
              sel_cat <= sel_first;
              last_bw <= sel_first_bw;
            end
          end
          OP_POP: begin
            if (fill[sel_cat] != '0) begin
              head[sel_cat] <= slot_inc(head[sel_cat]);
              fill[sel_cat] <= fill[sel_cat] - 1'b1;
              if (!last_bw) owed <= ratio;
              else if (owed != '0) owed <= owed - 1'b1;
            end
          end
          OP_CANCEL: begin
            if (!all_empty) begin
              tail[high_cat] <= tail_prev;
              fill[high_cat] <= fill[high_cat] - 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (state == B_SCAN_CMP && scan_i == high_cat) begin
        sel_cat <= take ? scan_i : best_cat;
        last_bw <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        res        <= res_idle;
        scan_i     <= low_cat;
        best_valid <= 1'b0;
      end
      B_SCAN_CMP: begin
        if (take) begin
          best_valid   <= 1'b1;
          best_clause  <= ram_q[ENTRY_W-1:PAYLOAD_W];
          best_payload <= ram_q[PAYLOAD_W-1:0];
          best_cat     <= scan_i;
        end
        if (scan_i == high_cat) begin
          res.ok                <= 1'b1;
          res.by_weight         <= 1'b0;
          res.out_clause_number <= take ? ram_q[ENTRY_W-1:PAYLOAD_W] : best_clause;
          res.out_payload       <= take ? ram_q[PAYLOAD_W-1:0] : best_payload;
          res.out_category      <= CATF_W'(take ? scan_i : best_cat);
        end else begin
          scan_i <= scan_i + 1'b1;
        end
      end
      B_READ: begin
        res.out_clause_number <= ram_q[ENTRY_W-1:PAYLOAD_W];
        res.out_payload       <= ram_q[PAYLOAD_W-1:0];
      end
      default: ;
    endcase
    if (state == B_RESP && o_load) begin
      o_res <= res;
    end
  end

  awbq_ram #(.WIDTH(ENTRY_W), .DEPTH(RAM_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  assign rsp.valid             = o_valid;
  assign rsp.ok                = o_res.ok;
  assign rsp.out_clause_number = o_res.out_clause_number;
  assign rsp.out_payload       = o_res.out_payload;
  assign rsp.out_category      = o_res.out_category;
  assign rsp.by_weight         = o_res.by_weight;

`ifndef SYNTHESIS
  a_we_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == B_IDLE && cmd.mode == OP_INSERT))
    else $error("store written outside insert");
  a_owed_pop: assert property (@(posedge clk) disable iff (rst)
    !(state == B_IDLE && cmd_valid && cmd.mode == OP_POP) |=> $stable(owed))
    else $error("owed count moved without pop");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN_CMP) |-> (scan_i <= high_cat && scan_i >= low_cat))
    else $error("scan index out of range");
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    (state == B_RESP && !o_load) |=> (state == B_RESP && $stable(res)))
    else $error("pending result lost");
`endif
endmodule

// ----- hw/rtl/age_weight_bucket_queue.sv -----
// ----------------------------------------------------------------------------
// age_weight_bucket_queue: age/weight bucketed priority queue
// Per-category FIFO rings with age or weight selection.
// ----------------------------------------------------------------------------
// Usage:
//  req carries one command word (mode, clause_number, weight_category,
//  payload); rsp returns exactly one result word per command, in order.
//  Config writes (cfg_we, cfg_index, cfg_data) set the age/weight ratio
//  (index 0) and the max priority mode (index 1); write only while idle.
//  A two-entry command queue decouples intake from the engine, so req
//  can take up to two commands while the engine works or a result waits.
//  Inserts, pops, cancels, peeks and weight selects pass through the
//  single-port entry store (write or registered read).
//  An age select walks category heads from the lowest to the highest
//  non-empty category, with a read and a compare step per category.
//  The engine takes a new command only once the last result has moved
//  on into the output register.
//  Reset (rst, synchronous) empties every ring, clears the owed count and
//  the selection; entry store contents need no clearing.
//  When rsp stalls, the result sits in the output register; the engine may
//  finish one more command and then holds it until the register frees.
// ----------------------------------------------------------------------------
module age_weight_bucket_queue (
  input  logic clk,
  input  logic rst,
  awbq_req_if.sink   req,
  awbq_rsp_if.source rsp,
  input  logic                            cfg_we,
  input  logic [awbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [awbq_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import awbq_pkg::*;

  logic [RATIO_W-1:0] ratio;
  logic               prio_mode;
  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_pop;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio     <= '0;
      prio_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATIO: ratio     <= cfg_data[RATIO_W-1:0];
        REG_PRIO:  prio_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  awbq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ratio     (ratio),
    .prio_mode (prio_mode),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  awbq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ratio     (ratio),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );
endmodule

// ----- tb/sv/age_weight_bucket_queue_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// age_weight_bucket_queue_tb: self-checking bench for the bucketed queue
// Drives command words through the request channel and checks every result
// word against an in-bench copy of the per-category rings, the age/weight
// selection and the owed weight-pick count. Runs directed corner cases, then
// random traffic under several ratio/priority settings and idle patterns.
// ----------------------------------------------------------------------------
module age_weight_bucket_queue_tb;
  import awbq_pkg::*;

  // Mode codes above the defined operations; the block answers them with ok 0.
  localparam logic [MODE_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 5000;
  // An age select walks up to 32 categories; settle margin.
  localparam int SETTLE_CYCLES = 100;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  awbq_req_if req ();
  awbq_rsp_if rsp ();

  age_weight_bucket_queue dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Queue model: one ring per category plus lowest/highest non-empty tracking
  // --------------------------------------------------------------------------
  logic [ENTRY_W-1:0] ring_mem [NUM_CATEGORIES][CATEGORY_DEPTH];
  logic [SLOT_W-1:0]  q_head [NUM_CATEGORIES];
  logic [SLOT_W-1:0]  q_tail [NUM_CATEGORIES];
  logic [FILL_W-1:0]  q_fill [NUM_CATEGORIES];
  int                 low_cat, high_cat;   // empty when low_cat > high_cat
  logic [RATIO_W-1:0] owed_picks;
  logic [CAT_W-1:0]   picked_cat;
  logic               picked_by_weight;
  logic [RATIO_W-1:0] ratio_reg;
  logic               prio_reg;

  rsp_t expected_words[$];
  int   n_words_sent, n_words_checked, n_errors, idle_cycles;
  int   send_idle_pct, recv_stall_pct;
  int   n_inserts_ok, n_weight_picks;

  function automatic rsp_t report_word(logic [ENTRY_W-1:0] e, int c, logic bw);
    rsp_t r;
    r.ok = 1'b1;
    r.out_clause_number = e[ENTRY_W-1:PAYLOAD_W];
    r.out_payload = e[PAYLOAD_W-1:0];
    r.out_category = CATF_W'(c);
    r.by_weight = bw;
    return r;
  endfunction

  function void rescan_bounds();
    low_cat = NUM_CATEGORIES;
    high_cat = -1;
    for (int c = 0; c < NUM_CATEGORIES; c++) begin
      if (q_fill[c] != 0) begin
        if (c < low_cat) low_cat = c;
        high_cat = c;
      end
    end
  endfunction

  // Applies one command to the model and returns the word it must produce.
  function rsp_t apply_command(logic [MODE_W-1:0] m, logic [CLAUSE_W-1:0] cl,
                               logic [CATF_W-1:0] ct, logic [PAYLOAD_W-1:0] pl);
    rsp_t r;
    int c;
    logic [SLOT_W-1:0] ts;
    r = '0;
    if (low_cat > high_cat && (m == OP_SELECT || m == OP_CANCEL || m == OP_PEEK))
      return r;
    case (m)
      OP_INSERT: begin
        c = (prio_reg || ratio_reg == 0) ? 0 : int'(ct);
        if (q_fill[c] >= CATEGORY_DEPTH) return r;
        ring_mem[c][q_tail[c]] = {cl, pl};
        q_tail[c] = q_tail[c] + 1'b1;
        q_fill[c] = q_fill[c] + 1'b1;
        if (c < low_cat) low_cat = c;
        if (c > high_cat) high_cat = c;
        n_inserts_ok++;
        r = report_word({cl, pl}, c, 1'b0);
      end
      OP_SELECT: begin
        if (low_cat == 0) begin
          picked_cat = '0;
          picked_by_weight = 1'b0;
        end else if (owed_picks == 0) begin
          c = low_cat;
          // strict compare: on equal age the lower category keeps the pick
          for (int i = low_cat + 1; i <= high_cat; i++)
            if (q_fill[i] != 0 && ring_mem[i][q_head[i]][ENTRY_W-1:PAYLOAD_W] <
                ring_mem[c][q_head[c]][ENTRY_W-1:PAYLOAD_W])
              c = i;
          picked_cat = CAT_W'(c);
          picked_by_weight = 1'b0;
        end else begin
          picked_cat = CAT_W'(low_cat);
          picked_by_weight = 1'b1;
          n_weight_picks++;
        end
        r = report_word(ring_mem[picked_cat][q_head[picked_cat]], int'(picked_cat),
                        picked_by_weight);
      end
      OP_POP: begin
        c = int'(picked_cat);
        if (q_fill[c] == 0) return r;
        r = report_word(ring_mem[c][q_head[c]], c, picked_by_weight);
        q_head[c] = q_head[c] + 1'b1;
        q_fill[c] = q_fill[c] - 1'b1;
        rescan_bounds();
        if (picked_by_weight) begin
          if (owed_picks != 0) owed_picks = owed_picks - 1'b1;
        end else begin
          owed_picks = ratio_reg;
        end
      end
      OP_CANCEL: begin
        c = high_cat;
        q_tail[c] = q_tail[c] - 1'b1;
        r = report_word(ring_mem[c][q_tail[c]], c, 1'b0);
        q_fill[c] = q_fill[c] - 1'b1;
        rescan_bounds();
      end
      OP_PEEK: begin
        c = high_cat;
        ts = q_tail[c] - 1'b1;
        r = report_word(ring_mem[c][ts], c, 1'b0);
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic send_word(logic [MODE_W-1:0] m, logic [CLAUSE_W-1:0] cl,
                           logic [CATF_W-1:0] ct, logic [PAYLOAD_W-1:0] pl);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= m;
    req.clause_number <= cl;
    req.weight_category <= ct;
    req.payload <= pl;
    do @(posedge clk); while (!req.ready);
    // word taken at this edge; model updates in acceptance order
    expected_words.push_back(apply_command(m, cl, ct, pl));
    n_words_sent++;
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Config only while idle: drain, let any engine work settle, then write.
  task automatic set_config(logic [RATIO_W-1:0] ratio, logic prio);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_RATIO;
    cfg_data <= ratio;
    @(posedge clk);
    cfg_index <= REG_PRIO;
    cfg_data <= CFG_DAT_W'(prio);
    @(posedge clk);
    cfg_we <= 1'b0;
    ratio_reg = ratio;
    prio_reg = prio;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, compare against oldest expectation, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rsp.valid && rsp.ready) begin
      rsp_t exp_w;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        n_errors++;
      end else begin
        exp_w = expected_words.pop_front();
        n_words_checked++;
        if (rsp.ok !== exp_w.ok) begin
          $error("ok: expected %0d, got %0d", exp_w.ok, rsp.ok);
          n_errors++;
        end
        if (rsp.out_clause_number !== exp_w.out_clause_number) begin
          $error("out_clause_number: expected %h, got %h",
                 exp_w.out_clause_number, rsp.out_clause_number);
          n_errors++;
        end
        if (rsp.out_payload !== exp_w.out_payload) begin
          $error("out_payload: expected %h, got %h", exp_w.out_payload, rsp.out_payload);
          n_errors++;
        end
        if (rsp.out_category !== exp_w.out_category) begin
          $error("out_category: expected %0d, got %0d",
                 exp_w.out_category, rsp.out_category);
          n_errors++;
        end
        if (rsp.by_weight !== exp_w.by_weight) begin
          $error("by_weight: expected %0d, got %0d", exp_w.by_weight, rsp.by_weight);
          n_errors++;
        end
      end
    end
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d words still expected", expected_words.size());
      $display("age_weight_bucket_queue_tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_empty_queue();
    send_word(OP_SELECT, '1, '1, '1);
    send_word(OP_POP, '0, '0, '0);
    send_word(OP_CANCEL, 32'h1234_5678, 5'd3, 32'hdead_beef);
    send_word(OP_PEEK, '0, '0, '0);
    for (int m = OP_UNUSED_LO; m <= OP_UNUSED_HI; m++)
      send_word(MODE_W'(m), $urandom, 5'($urandom), $urandom);
  endtask

  // ratio zero: every insert folds into category zero
  task automatic test_category_zero();
    send_word(OP_INSERT, 32'h0000_0000, 5'd31, 32'hffff_ffff);
    send_word(OP_INSERT, 32'hffff_ffff, 5'd5, 32'h0000_0000);
    send_word(OP_SELECT, '0, '0, '0);
    send_word(OP_POP, '0, '0, '0);
    send_word(OP_PEEK, '0, '0, '0);
    send_word(OP_CANCEL, '0, '0, '0);
    send_word(OP_POP, '0, '0, '0);   // selected category emptied by cancel
  endtask

  // age pick among equal and lower ages, then owed weight picks
  task automatic test_weight_select();
    set_config(8'd2, 1'b0);
    send_word(OP_INSERT, 32'd50, 5'd31, 32'h0a);
    send_word(OP_INSERT, 32'd50, 5'd9, 32'h0b);
    send_word(OP_INSERT, 32'd10, 5'd20, 32'h0c);
    send_word(OP_INSERT, 32'd70, 5'd9, 32'h0d);
    repeat (3) begin
      send_word(OP_SELECT, '0, '0, '0);
      send_word(OP_POP, '0, '0, '0);
    end
    send_word(OP_PEEK, '0, '0, '0);
    send_word(OP_CANCEL, '0, '0, '0);
  endtask

  // priority mode: fill category zero until the ring refuses
  task automatic test_ring_full();
    set_config(8'd1, 1'b1);
    for (int i = 0; i <= CATEGORY_DEPTH; i++)
      send_word(OP_INSERT, $urandom, 5'd17, $urandom);
  endtask

  task automatic test_random(int n_items);
    int pick;
    for (int i = 0; i < n_items; i++) begin
      case ((i * 4) / n_items)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      pick = $urandom_range(99);
      if (pick < 40)
        // narrow clause range half the time so age ties happen
        send_word(OP_INSERT, ($urandom_range(1) != 0) ? $urandom : $urandom_range(15),
                  5'($urandom), $urandom);
      else if (pick < 60) send_word(OP_SELECT, $urandom, 5'($urandom), $urandom);
      else if (pick < 80) send_word(OP_POP, $urandom, 5'($urandom), $urandom);
      else if (pick < 88) send_word(OP_CANCEL, $urandom, 5'($urandom), $urandom);
      else if (pick < 97) send_word(OP_PEEK, $urandom, 5'($urandom), $urandom);
      else send_word(MODE_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)), $urandom,
                     5'($urandom), $urandom);
    end
  endtask

  initial begin
    for (int c = 0; c < NUM_CATEGORIES; c++) begin
      q_head[c] = '0;
      q_tail[c] = '0;
      q_fill[c] = '0;
    end
    low_cat = NUM_CATEGORIES;
    high_cat = -1;
    owed_picks = '0;
    picked_cat = '0;
    picked_by_weight = 1'b0;
    ratio_reg = '0;
    prio_reg = 1'b0;
    n_words_sent = 0;
    n_inserts_ok = 0; n_weight_picks = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_RATIO;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.mode <= OP_INSERT;
    req.clause_number <= '0;
    req.weight_category <= '0;
    req.payload <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_category_zero();
    test_weight_select();
    test_ring_full();

    set_config(8'd255, 1'b0);
    test_random(300);
    // hold-off: let every result come back before carrying on
    drain_results();
    test_random(100);
    set_config(8'd1, 1'b0);
    test_random(300);
    set_config(8'd0, 1'b0);
    test_random(250);
    set_config(8'd3, 1'b1);
    test_random(250);
    set_config(8'd2, 1'b0);
    test_random(300);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d command words, %0d results checked, %0d inserts stored,",
             n_words_sent, n_words_checked, n_inserts_ok);
    $display("%0d weight picks, ratios 0..255, priority mode on and off", n_weight_picks);
    if (n_errors == 0 && expected_words.size() == 0)
      $display("age_weight_bucket_queue_tb: done, clean");
    else
      $display("age_weight_bucket_queue_tb: done, errors");
    $finish;
  end

endmodule
